### hw/rtl/brfrr_pkg.sv
// shared types and constants for the banked ring fifo with round-robin ring choice
package brfrr_pkg;

  localparam int CFG_WIDTH = 4;

  typedef struct packed {
    logic        op;
    logic [31:0] data;
    logic        last;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] data_out;
    logic [2:0]  ring_used;
  } out_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_VISIT  = 5'b00100,
    S_READ   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

endpackage

### hw/rtl/brfrr_store.sv
// word memory shared by all rings, one write port and one registered read port
module brfrr_store #(
  parameter int DATA_WIDTH = 32,
  parameter int WORDS      = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/banked_ring_fifo_round_robin_top.sv
// top level of the banked ring fifo with round-robin ring choice
//
// input channel (in_valid/in_ready/in_item) carries one push or pop per
// transaction; last ends the batch of that kind. output channel
// (out_valid/out_ready/out_item) returns exactly one result per input.
// cfg_we/cfg_wdata set the number of active rings (0 reads as 1, values
// above MAX_QUEUES saturate); write only while the block is idle.
// one item is worked at a time by a small sequencer around the word memory:
// for each ring visited by the item it takes one pointer step (with pointer
// reduction steps first after an active count change) and one ring check;
// a served pop adds a memory read. the next item is taken in the cycle
// after the result enters the output register.
// reset clears ring counters, pointers and batch state at once; no
// clearing pass runs, ring words are undefined until pushed.
// a stalled receiver holds the result in the output register; the block
// finishes the following item and then waits until the register frees.
module banked_ring_fifo_round_robin_top #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  brfrr_pkg::in_t                      in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output brfrr_pkg::out_t                     out_item,
  input  logic                                cfg_we,
  input  logic [brfrr_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

  localparam int RW    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int TW    = $clog2(MAX_QUEUES + 1);
  localparam int IW    = $clog2(QUEUE_DEPTH);
  localparam int WORDS = MAX_QUEUES * QUEUE_DEPTH;
  localparam int SAW   = $clog2(WORDS);
  localparam int ACT_RESET = (MAX_QUEUES < 8) ? MAX_QUEUES : 8;

  brfrr_pkg::state_t state;
  brfrr_pkg::in_t    item;
  brfrr_pkg::out_t   result;

  logic [brfrr_pkg::CFG_WIDTH-1:0] act;

  logic [RW-1:0] nxt   [2];
  logic [RW-1:0] cur   [2];
  logic [TW-1:0] tries [2];
  logic          dead  [2];
  logic [RW-1:0] tmp;

  logic [IW-1:0] widx  [MAX_QUEUES];
  logic [IW-1:0] ridx  [MAX_QUEUES];
  logic          wwrap [MAX_QUEUES];
  logic          rwrap [MAX_QUEUES];

  logic                  side;
  logic [RW-1:0]         c;
  logic                  ring_full;
  logic                  ring_empty;
  logic                  can;
  logic                  serve;
  logic                  st_we;
  logic                  st_re;
  logic [SAW-1:0]        st_waddr;
  logic [SAW-1:0]        st_raddr;
  logic [DATA_WIDTH-1:0] st_rdata;
  logic                  out_free;

  always_comb begin
    side       = item.op;
    c          = cur[side];
    ring_full  = (wwrap[c] != rwrap[c]) && (widx[c] == ridx[c]);
    ring_empty = (wwrap[c] == rwrap[c]) && (widx[c] == ridx[c]);
    can        = (side == brfrr_pkg::OP_POP) ? !ring_empty : !ring_full;
    serve      = (state == brfrr_pkg::S_SEARCH) && !dead[side] &&
                 (tries[side] != '0) && can;
    st_we      = serve && (side == brfrr_pkg::OP_PUSH);
    st_re      = serve && (side == brfrr_pkg::OP_POP);
    st_waddr   = SAW'(c) * SAW'(QUEUE_DEPTH) + SAW'(widx[c]);
    st_raddr   = SAW'(c) * SAW'(QUEUE_DEPTH) + SAW'(ridx[c]);
    out_free   = !out_valid || out_ready;
  end

  assign in_ready = (state == brfrr_pkg::S_IDLE);

  brfrr_store #(
    .DATA_WIDTH (DATA_WIDTH),
    .WORDS      (WORDS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (DATA_WIDTH'(item.data)),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // active ring count
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= brfrr_pkg::CFG_WIDTH'(ACT_RESET);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        act <= brfrr_pkg::CFG_WIDTH'(1);
      end else if (32'(cfg_wdata) > MAX_QUEUES) begin
        act <= brfrr_pkg::CFG_WIDTH'(MAX_QUEUES);
      end else begin
        act <= cfg_wdata;
      end
    end
  end

  // sequencer, batch state and ring counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brfrr_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        nxt[i]   <= '0;
        cur[i]   <= '0;
        tries[i] <= '0;
        dead[i]  <= 1'b0;
      end
      for (int q = 0; q < MAX_QUEUES; q++) begin
        widx[q]  <= '0;
        ridx[q]  <= '0;
        wwrap[q] <= 1'b0;
        rwrap[q] <= 1'b0;
      end
    end else begin
      if (out_valid && out_ready && (state != brfrr_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        brfrr_pkg::S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= brfrr_pkg::S_SEARCH;
          end
        end
        brfrr_pkg::S_SEARCH: begin
          priority if (dead[side]) begin
            result <= '0;
            state  <= brfrr_pkg::S_DONE;
          end else if (tries[side] == '0) begin
            tmp   <= nxt[side];
            state <= brfrr_pkg::S_VISIT;
          end else if (can) begin
            result.accepted  <= 1'b1;
            result.data_out  <= '0;
            result.ring_used <= 3'(c);
            if (side == brfrr_pkg::OP_PUSH) begin
              widx[c] <= (widx[c] == IW'(QUEUE_DEPTH - 1)) ? '0 : widx[c] + 1'b1;
              if (widx[c] == IW'(QUEUE_DEPTH - 1)) begin
                wwrap[c] <= !wwrap[c];
              end
              state <= brfrr_pkg::S_DONE;
            end else begin
              ridx[c] <= (ridx[c] == IW'(QUEUE_DEPTH - 1)) ? '0 : ridx[c] + 1'b1;
              if (ridx[c] == IW'(QUEUE_DEPTH - 1)) begin
                rwrap[c] <= !rwrap[c];
              end
              state <= brfrr_pkg::S_READ;
            end
          end else if (32'(tries[side]) >= 32'(act)) begin
            dead[side] <= 1'b1;
            result     <= '0;
            state      <= brfrr_pkg::S_DONE;
          end else begin
            tmp   <= nxt[side];
            state <= brfrr_pkg::S_VISIT;
          end
        end
        brfrr_pkg::S_VISIT: begin
          if (32'(tmp) >= 32'(act)) begin
            tmp <= RW'(32'(tmp) - 32'(act));
          end else begin
            cur[side]   <= tmp;
            nxt[side]   <= (32'(tmp) + 1 == 32'(act)) ? '0 : RW'(32'(tmp) + 1);
            tries[side] <= TW'(32'(tries[side]) + 1);
            state       <= brfrr_pkg::S_SEARCH;
          end
        end
        brfrr_pkg::S_READ: begin
          result.data_out <= 32'(st_rdata);
          state           <= brfrr_pkg::S_DONE;
        end
        brfrr_pkg::S_DONE: begin
          if (out_free) begin
            out_item  <= result;
            out_valid <= 1'b1;
            if (item.last) begin
              tries[side] <= '0;
              dead[side]  <= 1'b0;
            end
            state <= brfrr_pkg::S_IDLE;
          end
        end
        default: begin
          state <= brfrr_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/brfrr_checker.sv
// port-level checks for the banked ring fifo top, bound to the top level
module brfrr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input brfrr_pkg::out_t out_item
);

  // a rejected transaction carries no word and no ring
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.accepted |->
      (out_item.data_out == '0) && (out_item.ring_used == '0))
    else $error("rejected result carries data or ring");

  // one item at a time: no second acceptance in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in back to back cycles");

  // a result never appears in the cycle right after its item is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind banked_ring_fifo_round_robin_top brfrr_checker u_brfrr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### test/tb.sv
`timescale 1ns / 1ps
// testbench for the banked ring fifo with round-robin ring choice
module tb;

  localparam int RINGS = 8;
  localparam int RING_DEPTH = 16;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  brfrr_pkg::in_t in_item;
  logic out_valid;
  logic out_ready;
  brfrr_pkg::out_t out_item;
  logic cfg_we;
  logic [brfrr_pkg::CFG_WIDTH-1:0] cfg_wdata;

  banked_ring_fifo_round_robin_top #(
    .MAX_QUEUES(RINGS),
    .QUEUE_DEPTH(RING_DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // fifo model state
  logic [31:0] ring_words [RINGS*RING_DEPTH];
  logic [4:0] wr_pos [RINGS];
  logic [4:0] rd_pos [RINGS];
  logic [2:0] push_rr, pop_rr, push_ring, pop_ring;
  logic [3:0] push_visits, pop_visits;
  bit push_stuck, pop_stuck;
  int active_rings;

  brfrr_pkg::out_t pending_results[$];
  int mismatch_count;
  int cycle_count;
  int items_sent;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit ring_can_take(logic [2:0] ring, bit is_push);
    logic [4:0] fill;
    fill = wr_pos[ring] - rd_pos[ring];
    return is_push ? (fill < RING_DEPTH) : (fill != 0);
  endfunction

  function automatic void clear_fifo_model();
    for (int i = 0; i < RINGS; i++) begin
      wr_pos[i] = '0;
      rd_pos[i] = '0;
    end
    push_rr = '0;
    pop_rr = '0;
    push_ring = '0;
    pop_ring = '0;
    push_visits = '0;
    pop_visits = '0;
    push_stuck = 1'b0;
    pop_stuck = 1'b0;
    active_rings = RINGS;
  endfunction

  // returns the serving ring, or -1 when the batch has run out of rings
  function automatic int pick_ring(bit is_push);
    logic [2:0] rr, cur;
    logic [3:0] visits;
    bit stuck;
    int served;
    rr = is_push ? push_rr : pop_rr;
    cur = is_push ? push_ring : pop_ring;
    visits = is_push ? push_visits : pop_visits;
    stuck = is_push ? push_stuck : pop_stuck;
    served = -1;
    if (!stuck) begin
      if (visits == 0) begin
        cur = 3'(rr % active_rings);
        rr = 3'((cur + 1) % active_rings);
        visits++;
      end
      while (!stuck && !ring_can_take(cur, is_push)) begin
        if (visits >= active_rings) begin
          stuck = 1'b1;
        end else begin
          cur = 3'(rr % active_rings);
          rr = 3'((cur + 1) % active_rings);
          visits++;
        end
      end
      if (!stuck) served = int'(cur);
    end
    if (is_push) begin
      push_rr = rr;
      push_ring = cur;
      push_visits = visits;
      push_stuck = stuck;
    end else begin
      pop_rr = rr;
      pop_ring = cur;
      pop_visits = visits;
      pop_stuck = stuck;
    end
    return served;
  endfunction

  function automatic brfrr_pkg::out_t predict_fifo_result(brfrr_pkg::in_t item);
    brfrr_pkg::out_t res;
    bit is_push;
    int served;
    res = '0;
    is_push = (item.op == brfrr_pkg::OP_PUSH);
    served = pick_ring(is_push);
    if (served >= 0) begin
      res.accepted = 1'b1;
      res.ring_used = served[2:0];
      if (is_push) begin
        ring_words[served*RING_DEPTH + wr_pos[served][3:0]] = item.data;
        wr_pos[served] = wr_pos[served] + 1'b1;
      end else begin
        res.data_out = ring_words[served*RING_DEPTH + rd_pos[served][3:0]];
        rd_pos[served] = rd_pos[served] + 1'b1;
      end
    end
    if (item.last) begin
      if (is_push) begin
        push_visits = '0;
        push_stuck = 1'b0;
      end else begin
        pop_visits = '0;
        pop_stuck = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: expected %h, got %h", field, cycle_count,
               want, got);
  endfunction

  // result checker
  always @(posedge clk) begin
    brfrr_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transaction", '0, out_item.data_out);
      end else begin
        want = pending_results.pop_front();
        if (out_item.accepted !== want.accepted)
          note_mismatch("accepted", 32'(want.accepted), 32'(out_item.accepted));
        if (out_item.data_out !== want.data_out)
          note_mismatch("data_out", want.data_out, out_item.data_out);
        if (out_item.ring_used !== want.ring_used)
          note_mismatch("ring_used", 32'(want.ring_used), 32'(out_item.ring_used));
      end
    end
  end

  // receiver stalls
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap();
        out_ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  // entered and left at a falling edge; valid stays high when the next item follows
  task automatic send_item(logic op, logic [31:0] data, logic last);
    brfrr_pkg::in_t item;
    int gap;
    item.op = op;
    item.data = data;
    item.last = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_fifo_result(item));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_active_rings(logic [brfrr_pkg::CFG_WIDTH-1:0] value);
    int v;
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    v = int'(value);
    if (v < 1) v = 1;
    if (v > RINGS) v = RINGS;
    active_rings = v;
  endtask

  // one ring only: data extremes, pops past empty, rejected items closing batches
  task automatic test_single_ring();
    set_active_rings(4'd0);
    send_item(brfrr_pkg::OP_PUSH, 32'h0000_0000, 1'b0);
    send_item(brfrr_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    send_item(brfrr_pkg::OP_PUSH, 32'h5A5A_A5A5, 1'b1);
    send_item(brfrr_pkg::OP_POP, 32'hFFFF_FFFF, 1'b0);
    send_item(brfrr_pkg::OP_POP, 32'h0000_0000, 1'b0);
    send_item(brfrr_pkg::OP_POP, 32'h1234_5678, 1'b0);
    send_item(brfrr_pkg::OP_POP, 32'h0000_0000, 1'b0);
    send_item(brfrr_pkg::OP_POP, 32'h0000_0000, 1'b1);
    send_item(brfrr_pkg::OP_POP, 32'h0000_0000, 1'b1);
  endtask

  // pointer left beyond a reduced ring count, and count change inside a batch
  task automatic test_pointer_reduce();
    set_active_rings(4'd15);
    repeat (5) send_item(brfrr_pkg::OP_PUSH, $urandom, 1'b1);
    send_item(brfrr_pkg::OP_POP, $urandom, 1'b1);
    set_active_rings(4'd3);
    send_item(brfrr_pkg::OP_PUSH, $urandom, 1'b0);
    send_item(brfrr_pkg::OP_PUSH, $urandom, 1'b1);
    send_item(brfrr_pkg::OP_POP, $urandom, 1'b0);
    set_active_rings(4'd1);
    send_item(brfrr_pkg::OP_POP, $urandom, 1'b0);
    send_item(brfrr_pkg::OP_POP, $urandom, 1'b1);
    send_item(brfrr_pkg::OP_PUSH, $urandom, 1'b1);
  endtask

  task automatic test_back_to_back(int count);
    set_active_rings(4'd8);
    no_idle = 1'b1;
    for (int i = 0; i < count; i++)
      send_item(1'($urandom_range(0, 1)), $urandom, ($urandom_range(0, 3) == 0));
    no_idle = 1'b0;
  endtask

  task automatic test_random_batches(int count);
    logic [brfrr_pkg::CFG_WIDTH-1:0] phase_cfg [6];
    int phase, phase_end, push_bias, batch_len;
    logic op;
    phase_cfg = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd15, 4'd3};
    phase = 0;
    count += items_sent;
    while (items_sent < count) begin
      set_active_rings(phase < 6 ? phase_cfg[phase] :
                       brfrr_pkg::CFG_WIDTH'($urandom_range(0, 15)));
      phase++;
      phase_end = items_sent + $urandom_range(40, 90);
      push_bias = $urandom_range(20, 80);
      while (items_sent < phase_end && items_sent < count) begin
        if ($urandom_range(0, 9) < 8) begin
          op = ($urandom_range(0, 99) < push_bias) ? brfrr_pkg::OP_PUSH : brfrr_pkg::OP_POP;
          batch_len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) :
                      $urandom_range(1, 5);
          for (int i = 0; i < batch_len; i++)
            send_item(op, $urandom, (i == batch_len - 1));
        end else begin
          send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    items_sent = 0;
    clear_fifo_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_single_ring();
    test_pointer_reduce();
    test_back_to_back(60);
    test_random_batches(420);
    drain_results();
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/brfrr_pkg.sv
hw/rtl/brfrr_store.sv
hw/rtl/banked_ring_fifo_round_robin_top.sv
hw/rtl/brfrr_checker.sv
test/tb.sv
